[src/qcm_pkg.sv]
// Shared types and constants for the quadratic chaotic map block.
package qcm_pkg;
   localparam int FRAC_BITS_DEF = 60;
   localparam int WORD_BITS_DEF = 64;
   localparam int NUM_COEFS = 12;
   localparam int IDX_W = 4;
   localparam int CMD_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEED = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

   typedef enum logic [1:0] {
      OP_SEED = 2'b01,
      OP_STEP = 2'b10
   } op_type;
endpackage

[src/qcm_front.sv]
// Front end: decodes commands, stores coefficients, queues seed and step beats.
module qcm_front #(
   parameter int WORD_BITS = qcm_pkg::WORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [qcm_pkg::CMD_W-1:0]    req_command,
   input  logic [qcm_pkg::IDX_W-1:0]    req_coef_index,
   input  logic signed [63:0]           req_coef_value,
   input  logic signed [63:0]           req_seed_x,
   input  logic signed [63:0]           req_seed_y,
   output logic                         q_valid,
   input  logic                         q_take,
   input  logic                         back_busy,
   output qcm_pkg::op_type              q_op,
   output logic [WORD_BITS-1:0]         q_x,
   output logic [WORD_BITS-1:0]         q_y,
   output logic [WORD_BITS-1:0]         coef [qcm_pkg::NUM_COEFS]
);
   localparam int D = qcm_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(D);

   logic [WORD_BITS-1:0] coef_ff [qcm_pkg::NUM_COEFS];
   qcm_pkg::op_type      op_ff [D];
   logic [WORD_BITS-1:0] x_ff [D];
   logic [WORD_BITS-1:0] y_ff [D];
   logic [PW-1:0]        wp_ff, rp_ff;
   logic [PW:0]          cnt_ff;
   logic                 acc, enq, deq;

   // a load waits until no queued beat and no running step can still read the coefficients
   assign req_full = (cnt_ff == (PW+1)'(D)) ||
                     (req_command == qcm_pkg::CMD_LOAD && (cnt_ff != '0 || back_busy));
   assign acc = req_push && !req_full;
   assign enq = acc && (req_command == qcm_pkg::CMD_SEED || req_command == qcm_pkg::CMD_STEP);
   assign q_valid = (cnt_ff != '0);
   assign deq = q_valid && q_take;
   assign q_op = op_ff[rp_ff];
   assign q_x = x_ff[rp_ff];
   assign q_y = y_ff[rp_ff];
   assign coef = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         for (int i = 0; i < qcm_pkg::NUM_COEFS; i++) coef_ff[i] <= '0;
      end else begin
         if (acc && req_command == qcm_pkg::CMD_LOAD &&
             req_coef_index < qcm_pkg::IDX_W'(qcm_pkg::NUM_COEFS))
            coef_ff[req_coef_index] <= req_coef_value[WORD_BITS-1:0];
         if (enq) begin
            op_ff[wp_ff] <= (req_command == qcm_pkg::CMD_SEED) ?
                            qcm_pkg::OP_SEED : qcm_pkg::OP_STEP;
            x_ff[wp_ff] <= req_seed_x[WORD_BITS-1:0];
            y_ff[wp_ff] <= req_seed_y[WORD_BITS-1:0];
            wp_ff <= (wp_ff == PW'(D-1)) ? '0 : wp_ff + 1'b1;
         end
         if (deq) rp_ff <= (rp_ff == PW'(D-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(enq) - (PW+1)'(deq);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !enq) else $error("queue overflow");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(D)) else $error("count out of range");
   a_deq_nonempty: assert property (@(posedge clock) disable iff (reset)
      deq |-> cnt_ff != '0) else $error("pop of empty queue");
endmodule

[src/qcm_back.sv]
// Back end: sequencer over one shared 32x32 multiplier, result register.
module qcm_back #(
   parameter int WORD_BITS = qcm_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qcm_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   output logic                  back_busy,
   input  qcm_pkg::op_type       q_op,
   input  logic [WORD_BITS-1:0]  q_x,
   input  logic [WORD_BITS-1:0]  q_y,
   input  logic [WORD_BITS-1:0]  coef [qcm_pkg::NUM_COEFS],
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic signed [63:0]    rsp_x_out,
   output logic signed [63:0]    rsp_y_out
);
   // micro-op indices: sequence of 11 products, 4 partials each
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int NOPS = 11;
   localparam int OW = $clog2(NOPS);

   state_type            st_ff, st_in;
   logic [OW-1:0]        op_ff;
   logic [2:0]           ph_ff;
   logic [63:0]          a_ff, b_ff;
   logic [127:0]         acc_ff;
   logic [WORD_BITS-1:0] x_ff, y_ff, t_ff [3];
   logic [WORD_BITS-1:0] nx_ff, ny_ff;
   logic                 full_ff;
   logic [63:0]          pp_ff;
   logic [WORD_BITS-1:0] prod, sa, sb;
   logic [31:0]          ma, mb;

   function automatic logic [63:0] sx(input logic [WORD_BITS-1:0] v);
      sx = 64'(signed'(v));
   endfunction

   // operand select per product; t regs hold intermediate products/sums
   always_comb begin
      sa = '0;
      sb = '0;
      case (op_ff)
         4'd0:  begin sa = coef[2];  sb = x_ff; end
         4'd1:  begin sa = t_ff[0];  sb = x_ff; end
         4'd2:  begin sa = x_ff;     sb = y_ff; end
         4'd3:  begin sa = t_ff[2];  sb = coef[3]; end
         4'd4:  begin sa = coef[5];  sb = y_ff; end
         4'd5:  begin sa = t_ff[0];  sb = y_ff; end
         4'd6:  begin sa = coef[8];  sb = x_ff; end
         4'd7:  begin sa = t_ff[0];  sb = x_ff; end
         4'd8:  begin sa = t_ff[2];  sb = coef[9]; end
         4'd9:  begin sa = coef[11]; sb = y_ff; end
         4'd10: begin sa = t_ff[0];  sb = y_ff; end
         default: begin sa = '0; sb = '0; end
      endcase
   end

   // ph 0 loads operands, ph 1..4 issue partials, ph 5 accumulate last, ph 6 finish
   always_comb begin
      ma = a_ff[31:0];
      mb = b_ff[31:0];
      case (ph_ff)
         3'd2: begin ma = a_ff[31:0];  mb = b_ff[63:32]; end
         3'd3: begin ma = a_ff[63:32]; mb = b_ff[31:0];  end
         3'd4: begin ma = a_ff[63:32]; mb = b_ff[63:32]; end
         default: begin ma = a_ff[31:0]; mb = b_ff[31:0]; end
      endcase
   end

   logic [127:0] pp_sh;
   always_comb begin
      case (ph_ff)
         3'd3, 3'd4: pp_sh = {32'd0, pp_ff, 32'd0};
         3'd5:       pp_sh = {pp_ff, 64'd0};
         default:    pp_sh = {64'd0, pp_ff};
      endcase
   end

   logic [127:0] full_p;
   assign full_p = acc_ff - ((a_ff[63] ? {b_ff, 64'd0} : '0)) -
                   ((b_ff[63] ? {a_ff, 64'd0} : '0));
   assign prod = full_p[FRAC_BITS +: WORD_BITS];

   assign q_take = (st_ff == ST_IDLE) && q_valid && !full_ff;
   assign back_busy = (st_ff == ST_MUL);
   assign rsp_empty = !full_ff;
   assign rsp_x_out = sx(nx_ff);
   assign rsp_y_out = sx(ny_ff);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (q_take) st_in = (q_op == qcm_pkg::OP_SEED) ? ST_DONE : ST_MUL;
         ST_MUL:  if (op_ff == OW'(10) && ph_ff == 3'd6) st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         full_ff <= 1'b0;
         op_ff <= '0;
         ph_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (full_ff && rsp_pop) full_ff <= 1'b0;
         if (q_take) begin
            op_ff <= '0;
            ph_ff <= '0;
            if (q_op == qcm_pkg::OP_SEED) begin
               x_ff <= q_x;
               y_ff <= q_y;
            end
         end
         if (st_ff == ST_MUL) begin
            pp_ff <= ma * mb;
            case (ph_ff)
               3'd0: begin
                  a_ff <= sx(sa);
                  b_ff <= sx(sb);
                  acc_ff <= '0;
               end
               3'd1: ;
               default: acc_ff <= acc_ff + pp_sh;
            endcase
            if (ph_ff == 3'd6) begin
               ph_ff <= '0;
               op_ff <= op_ff + 1'b1;
               case (op_ff)
                  4'd0:  t_ff[0] <= prod + coef[1];
                  4'd6:  t_ff[0] <= prod + coef[7];
                  4'd4:  t_ff[0] <= prod + coef[4];
                  4'd9:  t_ff[0] <= prod + coef[10];
                  4'd1, 4'd7: t_ff[1] <= prod;
                  4'd2:  t_ff[2] <= prod;
                  4'd3, 4'd8: t_ff[1] <= t_ff[1] + prod;
                  4'd5:  nx_ff <= coef[0] + t_ff[1] + prod;
                  4'd10: ny_ff <= coef[6] + t_ff[1] + prod;
                  default: ;
               endcase
            end else ph_ff <= ph_ff + 1'b1;
         end
         if (st_ff == ST_DONE) begin
            full_ff <= 1'b1;
            // a finished step leaves the op counter past the last product; a seed leaves it at 0
            if (op_ff == OW'(11)) begin
               x_ff <= nx_ff;
               y_ff <= ny_ff;
            end else begin
               nx_ff <= x_ff;
               ny_ff <= y_ff;
            end
         end
      end
   end

   a_done_fills: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DONE |=> full_ff) else $error("result not posted");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !full_ff) else $error("take while result pending");
   a_ph_bound: assert property (@(posedge clock) disable iff (reset)
      ph_ff <= 3'd6) else $error("phase out of range");
endmodule

[src/quadratic_chaotic_map_q3_60.sv]
// Top level of the quadratic chaotic map block.
// A seed result is posted with no products once the back takes the beat; a step result follows
// its 11 products on one shared 32x32 multiplier and is then posted to the result register.
// The back works on one beat at a time and takes nothing new while a result waits; the
// front queues beats meanwhile. A load holds (full) until queue and multiplier idle.
// Reset (synchronous, active high) clears coefficients, the point and all queues.
module quadratic_chaotic_map_q3_60 #(
   parameter int WORD_BITS = qcm_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qcm_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [qcm_pkg::CMD_W-1:0]  req_command,
   input  logic [qcm_pkg::IDX_W-1:0]  req_coef_index,
   input  logic signed [63:0]         req_coef_value,
   input  logic signed [63:0]         req_seed_x,
   input  logic signed [63:0]         req_seed_y,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [63:0]         rsp_x_out,
   output logic signed [63:0]         rsp_y_out
);
   logic                 q_valid, q_take, back_busy;
   qcm_pkg::op_type      q_op;
   logic [WORD_BITS-1:0] q_x, q_y;
   logic [WORD_BITS-1:0] coef [qcm_pkg::NUM_COEFS];

   // front: decode and coefficient store; loads wait while a step may still read coefficients
   qcm_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_command, .req_coef_index,
      .req_coef_value, .req_seed_x, .req_seed_y,
      .q_valid, .q_take, .back_busy, .q_op, .q_x, .q_y, .coef
   );

   // back: multiply sequencer and result register
   qcm_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_take, .back_busy, .q_op, .q_x, .q_y, .coef,
      .rsp_empty, .rsp_pop, .rsp_x_out, .rsp_y_out
   );
endmodule

[tb/tb_quadratic_chaotic_map_q3_60.sv]
// Testbench for the quadratic chaotic map block: scoreboard with map predictor plus drivers.
`timescale 1ns / 1ps

class qcm_scoreboard;
   logic signed [63:0] coefs[qcm_pkg::NUM_COEFS];
   logic signed [63:0] px, py;
   logic signed [63:0] exp_x[$];
   logic signed [63:0] exp_y[$];
   int errors;
   int points_seen;

   function new();
      foreach (coefs[i]) coefs[i] = '0;
      px = '0;
      py = '0;
      errors = 0;
      points_seen = 0;
   endfunction

   // full signed product, floored by 60 and wrapped to 64 bits
   function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b);
      p = p >>> 60;
      return p[63:0];
   endfunction

   function logic signed [63:0] coord(int base, logic signed [63:0] x,
                                      logic signed [63:0] y);
      logic signed [63:0] tx, txy, ty;
      tx  = qmul(qmul(coefs[base+2], x) + coefs[base+1], x);
      txy = qmul(qmul(x, y), coefs[base+3]);
      ty  = qmul(qmul(coefs[base+5], y) + coefs[base+4], y);
      return coefs[base] + tx + txy + ty;
   endfunction

   function void note_beat(logic [1:0] cmd, logic [3:0] idx, logic signed [63:0] cv,
                           logic signed [63:0] sx, logic signed [63:0] sy);
      logic signed [63:0] nx, ny;
      if (cmd == qcm_pkg::CMD_LOAD) begin
         if (idx < qcm_pkg::NUM_COEFS) coefs[idx] = cv;
      end else if (cmd == qcm_pkg::CMD_SEED) begin
         px = sx;
         py = sy;
         exp_x.push_back(px);
         exp_y.push_back(py);
      end else if (cmd == qcm_pkg::CMD_STEP) begin
         nx = coord(0, px, py);
         ny = coord(6, px, py);
         px = nx;
         py = ny;
         exp_x.push_back(px);
         exp_y.push_back(py);
      end
   endfunction

   function void check_point(logic signed [63:0] x, logic signed [63:0] y);
      logic signed [63:0] ex, ey;
      points_seen++;
      if (exp_x.size() == 0) begin
         $error("unexpected point x=%h y=%h", x, y);
         errors++;
         return;
      end
      ex = exp_x.pop_front();
      ey = exp_y.pop_front();
      if (x !== ex) begin
         $error("x_out: expected %h actual %h", ex, x);
         errors++;
      end
      if (y !== ey) begin
         $error("y_out: expected %h actual %h", ey, y);
         errors++;
      end
   endfunction

   function int pending();
      return exp_x.size();
   endfunction
endclass

module tb_quadratic_chaotic_map_q3_60;
   localparam int WATCHDOG = 20000;   // far longer than a step; the receiver's long hold-off is far shorter
   localparam int DRAIN = 200;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [qcm_pkg::CMD_W-1:0] req_command = '0;
   logic [qcm_pkg::IDX_W-1:0] req_coef_index = '0;
   logic signed [63:0] req_coef_value = '0;
   logic signed [63:0] req_seed_x = '0;
   logic signed [63:0] req_seed_y = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic signed [63:0] rsp_x_out, rsp_y_out;

   quadratic_chaotic_map_q3_60 u_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   qcm_scoreboard board = new();
   int send_idle_pct;   // sender idle chance in percent
   int recv_idle_pct;   // receiver idle chance in percent
   bit recv_hold;       // long receiver hold-off in progress
   bit stim_done;
   int quiet_cycles;
   int beats_in;

   // Scoreboard update at the rising edge; accept rules straight from the queue handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            board.note_beat(req_command, req_coef_index, req_coef_value,
                            req_seed_x, req_seed_y);
            beats_in++;
         end
         if (rsp_pop && !rsp_empty) board.check_point(rsp_x_out, rsp_y_out);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d points pending", board.pending());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Receiver: pops at random, held off entirely while recv_hold is set.
   always @(negedge clock) begin
      if (reset || recv_hold) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Random Q3.60 value: mostly small magnitudes so orbits stay interesting, some raw.
   function automatic logic signed [63:0] rand_val();
      logic signed [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return v;
         1: return v >>> 4;
         default: return v >>> 7;
      endcase
   endfunction

   // One beat: drive at the falling edge, wait for acceptance, maybe idle after.
   task automatic send_beat(logic [1:0] cmd, logic [3:0] idx, logic signed [63:0] cv,
                            logic signed [63:0] sx, logic signed [63:0] sy);
      req_push <= 1'b1;
      req_command <= cmd;
      req_coef_index <= idx;
      req_coef_value <= cv;
      req_seed_x <= sx;
      req_seed_y <= sy;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         req_command <= 2'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic load(int idx, logic signed [63:0] v);
      send_beat(qcm_pkg::CMD_LOAD, 4'(idx), v, rand_val(), rand_val());
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic random_beat();
      int r;
      r = $urandom_range(99);
      if (r < 8) send_beat(qcm_pkg::CMD_LOAD, 4'($urandom_range(11)), rand_val(), rand_val(),
                           rand_val());
      else if (r < 10) send_beat(qcm_pkg::CMD_LOAD, 4'($urandom_range(15, 12)), rand_val(),
                                 rand_val(), rand_val());
      else if (r < 12) send_beat(qcm_pkg::CMD_RSVD, 4'($urandom), rand_val(), rand_val(),
                                 rand_val());
      else if (r < 22) send_beat(qcm_pkg::CMD_SEED, 4'($urandom), rand_val(), rand_val(),
                                 rand_val());
      else send_beat(qcm_pkg::CMD_STEP, 4'($urandom), rand_val(), rand_val(), rand_val());
   endtask

   initial begin
      logic signed [63:0] maxv, minv, one;
      maxv = 64'h7fff_ffff_ffff_ffff;
      minv = 64'h8000_0000_0000_0000;
      one = 64'sd1 <<< 60;
      stim_done = 0;
      recv_hold = 0;
      quiet_cycles = 0;
      beats_in = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: step from reset state, seeds at extremes, coefficient extremes
      send_beat(qcm_pkg::CMD_STEP, '0, '0, '0, '0);
      send_beat(qcm_pkg::CMD_SEED, '0, '0, maxv, minv);
      send_beat(qcm_pkg::CMD_STEP, '0, '0, '0, '0);
      for (int i = 0; i < qcm_pkg::NUM_COEFS; i++) load(i, (i % 2) ? minv : maxv);
      send_beat(qcm_pkg::CMD_LOAD, 4'd12, one, '0, '0);   // index out of range: ignored
      send_beat(qcm_pkg::CMD_LOAD, 4'd15, maxv, '0, '0);
      send_beat(qcm_pkg::CMD_RSVD, 4'hf, maxv, maxv, maxv);   // unused command
      send_beat(qcm_pkg::CMD_SEED, 4'hf, '0, -64'sd1, maxv);
      send_beat(qcm_pkg::CMD_STEP, '0, '0, '0, '0);
      send_beat(qcm_pkg::CMD_SEED, '0, '0, minv, minv);
      send_beat(qcm_pkg::CMD_STEP, '0, '0, '0, '0);
      send_beat(qcm_pkg::CMD_SEED, '0, '0, one, -one);
      send_beat(qcm_pkg::CMD_STEP, '0, '0, '0, '0);
      // sender pauses until every point has come back
      wait_drained();

      // a reasonable map, then random traffic in three idling phases
      for (int i = 0; i < qcm_pkg::NUM_COEFS; i++) load(i, rand_val() >>> 2);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 62 : 0;
         recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 38 : 0;
         if (ph == 2) begin
            // receiver holds off long enough for the block to back up
            fork
               begin
                  recv_hold = 1;
                  repeat (600) @(negedge clock);
                  recv_hold = 0;
               end
               repeat (12) send_beat(qcm_pkg::CMD_STEP, '0, '0, '0, '0);
            join
         end
         repeat (330) random_beat();
         wait_drained();
      end

      stim_done = 1;
      req_push <= 1'b0;
      repeat (DRAIN) @(negedge clock);
      $display("covered %0d input beats and %0d returned points", beats_in, board.points_seen);
      $display("coefficient loads, seeds, steps, ignored indices and command 3 included");
      if (board.errors == 0 && board.pending() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
